@@ rtl/core/bfe_pkg.sv @@
package bfe_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int LB_DEPTH   = 4096;
  localparam int LB_AW      = $clog2(LB_DEPTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN_N      = 9;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SH   = 16;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [COORD_W-1:0] WIDTH_M1_RST  = COORD_W'(639);
  localparam logic [COORD_W-1:0] HEIGHT_M1_RST = COORD_W'(479);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    pix_t [WIN_N-1:0] win;
    coord_t           row;
    coord_t           col;
    logic [3:0]       mask;
  } job_t;

  // Converts a written dimension, saturated to 1..limit, into its last index.
  function automatic coord_t last_index(input logic [DIM_W-1:0] value, input int limit);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(limit);
    if (value == '0) begin
      last_index = '0;
    end else if (value > lim) begin
      last_index = COORD_W'(lim - DIM_W'(1));
    end else begin
      last_index = COORD_W'(value - DIM_W'(1));
    end
  endfunction

  // Scaled reciprocal of a count of 1, 2, 3, 4, 6 or 9 pixels; exact for their sums.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    case (cnt)
      CNT_W'(1): recip = RECIP_W'(65536);
      CNT_W'(2): recip = RECIP_W'(32768);
      CNT_W'(3): recip = RECIP_W'(21846);
      CNT_W'(4): recip = RECIP_W'(16384);
      CNT_W'(6): recip = RECIP_W'(10923);
      CNT_W'(9): recip = RECIP_W'(7282);
      default:   recip = '0;
    endcase
  endfunction

endpackage

@@ rtl/core/box_filter_3x3_edge_aware.sv @@
// Port group   Direction  Handshake            Contents
// in_*         input      in_valid / in_stall  in_pixel_in, one pixel in raster order
// out_*        output     out_valid/out_stall  out_smoothed, out_row, out_col,
//                                              out_run_end, out_frame_end
// cfg_*        input      cfg_we               cfg_index, cfg_wdata
//
// The block takes one pixel per cycle and gives at most one result per cycle,
// while neither side stalls. The last pixel of a row after the first gives two
// results, the last pixel of a frame four, and on the last row every pixel from
// the second column on gives two, so there the input stalls once the four-item
// queue between the line-store front and the averaging back holds three items.
// Reset clears the window, position and queue; the line store needs no clearing.
// Stalls on either side only stop that side until the queue fills or drains.
module box_filter_3x3_edge_aware (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfe_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_smoothed,
  output logic [11:0]                   out_row,
  output logic [11:0]                   out_col,
  output logic                          out_run_end,
  output logic                          out_frame_end
);

  logic          q_afull, push_valid, head_valid, pop;
  bfe_pkg::job_t push_job, head_job;

  bfe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_pixel_in (in_pixel_in),
    .in_stall    (in_stall),
    .q_afull     (q_afull),
    .push_valid  (push_valid),
    .push_job    (push_job)
  );

  bfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .q_afull    (q_afull),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  bfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_smoothed  (out_smoothed),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ rtl/core/bfe_ram.sv @@
module bfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bfe_front.sv @@
module bfe_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfe_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  input  bfe_pkg::pix_t                    in_pixel_in,
  output logic                             in_stall,
  input  logic                             q_afull,
  output logic                             push_valid,
  output bfe_pkg::job_t                    push_job
);

  logic           accept;
  logic           last_col, last_row;
  bfe_pkg::coord_t width_m1_r, width_m1_nxt;
  bfe_pkg::coord_t height_m1_r, height_m1_nxt;
  bfe_pkg::coord_t row_r, row_nxt, col_r, col_nxt;

  logic            a_valid_r;
  bfe_pkg::pix_t   a_pix_r;
  bfe_pkg::coord_t a_row_r, a_col_r;
  logic            a_last_col_r, a_last_row_r;
  logic            fwd_r, fwd_nxt;
  logic [2*bfe_pkg::PIX_W-1:0] fwd_data_r;

  logic [2*bfe_pkg::PIX_W-1:0] ram_rdata, line_data, wr_data;
  bfe_pkg::pix_t upper, lower;
  bfe_pkg::pix_t [bfe_pkg::WIN_N-1:0] win_r, win_nxt;
  logic [3:0] mask;

  assign in_stall = q_afull;
  assign accept   = in_valid && !q_afull;
  assign last_col = (col_r == width_m1_r);
  assign last_row = (row_r == height_m1_r);

  always_comb begin
    width_m1_nxt  = width_m1_r;
    height_m1_nxt = height_m1_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    if (cfg_we && (cfg_index == bfe_pkg::REG_IMAGE_WIDTH)) begin
      width_m1_nxt = bfe_pkg::last_index(cfg_wdata, bfe_pkg::LB_DEPTH);
      row_nxt      = '0;
      col_nxt      = '0;
    end else if (cfg_we && (cfg_index == bfe_pkg::REG_IMAGE_HEIGHT)) begin
      height_m1_nxt = bfe_pkg::last_index(cfg_wdata, bfe_pkg::MAX_HEIGHT);
      row_nxt       = '0;
      col_nxt       = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + bfe_pkg::COORD_W'(1);
      end else begin
        col_nxt = col_r + bfe_pkg::COORD_W'(1);
      end
    end
  end

  assign fwd_nxt = accept && a_valid_r && (a_col_r == col_r);

  bfe_ram #(
    .WIDTH (2 * bfe_pkg::PIX_W),
    .DEPTH (bfe_pkg::LB_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_valid_r),
    .waddr (a_col_r[bfe_pkg::LB_AW-1:0]),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_r[bfe_pkg::LB_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign line_data = fwd_r ? fwd_data_r : ram_rdata;
  assign upper     = line_data[bfe_pkg::PIX_W-1:0];
  assign lower     = line_data[2*bfe_pkg::PIX_W-1:bfe_pkg::PIX_W];
  assign wr_data   = {a_pix_r, lower};

  always_comb begin
    win_nxt = win_r;
    if (a_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win_nxt[i*3]     = win_r[i*3+1];
        win_nxt[i*3 + 1] = win_r[i*3+2];
      end
      win_nxt[2] = upper;
      win_nxt[5] = lower;
      win_nxt[8] = a_pix_r;
    end
  end

  assign mask[0] = (a_row_r != '0) && (a_col_r != '0);
  assign mask[1] = (a_row_r != '0) && a_last_col_r;
  assign mask[2] = a_last_row_r && (a_col_r != '0);
  assign mask[3] = a_last_row_r && a_last_col_r;

  assign push_valid    = a_valid_r && (mask != '0);
  assign push_job.win  = win_nxt;
  assign push_job.row  = a_row_r;
  assign push_job.col  = a_col_r;
  assign push_job.mask = mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= bfe_pkg::WIDTH_M1_RST;
      height_m1_r <= bfe_pkg::HEIGHT_M1_RST;
      row_r       <= '0;
      col_r       <= '0;
      a_valid_r   <= 1'b0;
      fwd_r       <= 1'b0;
      win_r       <= '0;
    end else begin
      width_m1_r  <= width_m1_nxt;
      height_m1_r <= height_m1_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      a_valid_r   <= accept;
      fwd_r       <= fwd_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r      <= in_pixel_in;
      a_row_r      <= row_r;
      a_col_r      <= col_r;
      a_last_col_r <= last_col;
      a_last_row_r <= last_row;
    end
    fwd_data_r <= wr_data;
  end

endmodule

@@ rtl/core/bfe_queue.sv @@
module bfe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  bfe_pkg::job_t push_job,
  output logic          q_afull,
  output logic          head_valid,
  output bfe_pkg::job_t head_job,
  input  logic          pop
);

  bfe_pkg::job_t q_r [bfe_pkg::QUEUE_DEPTH];
  logic [bfe_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [bfe_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign head_valid = (count_r != '0);
  assign head_job   = q_r[rd_ptr_r];
  assign q_afull    = (count_r >= bfe_pkg::QCNT_W'(bfe_pkg::QUEUE_DEPTH - 1));
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + bfe_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + bfe_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid && !do_pop) begin
      count_nxt = count_r + bfe_pkg::QCNT_W'(1);
    end else if (!push_valid && do_pop) begin
      count_nxt = count_r - bfe_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/core/bfe_back.sv @@
module bfe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  bfe_pkg::job_t              head_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bfe_pkg::pix_t              out_smoothed,
  output bfe_pkg::coord_t            out_row,
  output bfe_pkg::coord_t            out_col,
  output logic                       out_run_end,
  output logic                       out_frame_end
);

  logic       adv, issue, last;
  logic [3:0] done_r, done_nxt, pend, pick;
  logic [1:0] k, r0, c0, nr, nc;
  logic [bfe_pkg::SUM_W-1:0] sum;
  logic [bfe_pkg::CNT_W-1:0] cnt;

  logic                      s1_valid_r;
  logic [bfe_pkg::SUM_W-1:0] s1_sum_r;
  logic [bfe_pkg::CNT_W-1:0] s1_cnt_r;
  bfe_pkg::coord_t           s1_row_r, s1_col_r;
  logic                      s1_run_end_r, s1_frame_end_r;
  logic [bfe_pkg::PROD_W-1:0] prod;

  logic            out_valid_r;
  bfe_pkg::pix_t   out_smoothed_r;
  bfe_pkg::coord_t out_row_r, out_col_r;
  logic            out_run_end_r, out_frame_end_r;

  assign adv   = !out_valid_r || !out_stall;
  assign issue = adv && head_valid;
  assign pend  = head_job.mask & ~done_r;
  assign pick  = pend & (~pend + 4'd1);
  assign last  = ((pend & ~pick) == '0);
  assign pop   = issue && last;

  always_comb begin
    case (pick)
      4'b0001: k = 2'd0;
      4'b0010: k = 2'd1;
      4'b0100: k = 2'd2;
      4'b1000: k = 2'd3;
      default: k = 2'd0;
    endcase
  end

  always_comb begin
    done_nxt = done_r;
    if (issue) begin
      done_nxt = last ? '0 : (done_r | pick);
    end
  end

  always_comb begin
    if (!k[1]) begin
      r0 = (head_job.row > bfe_pkg::COORD_W'(1)) ? 2'd0 : 2'd1;
    end else begin
      r0 = (head_job.row != '0) ? 2'd1 : 2'd2;
    end
    if (!k[0]) begin
      c0 = (head_job.col > bfe_pkg::COORD_W'(1)) ? 2'd0 : 2'd1;
    end else begin
      c0 = (head_job.col != '0) ? 2'd1 : 2'd2;
    end
    nr  = 2'd3 - r0;
    nc  = 2'd3 - c0;
    cnt = {2'b00, nr} * {2'b00, nc};
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if ((2'(i) >= r0) && (2'(j) >= c0)) begin
          sum = sum + bfe_pkg::SUM_W'(head_job.win[i*3+j]);
        end
      end
    end
  end

  assign prod = bfe_pkg::PROD_W'(s1_sum_r) * bfe_pkg::PROD_W'(bfe_pkg::recip(s1_cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      if (adv) begin
        s1_valid_r  <= issue;
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sum_r       <= sum;
      s1_cnt_r       <= cnt;
      s1_row_r       <= k[1] ? head_job.row : head_job.row - bfe_pkg::COORD_W'(1);
      s1_col_r       <= k[0] ? head_job.col : head_job.col - bfe_pkg::COORD_W'(1);
      s1_run_end_r   <= last;
      s1_frame_end_r <= (k == 2'd3);
    end
    if (adv && s1_valid_r) begin
      out_smoothed_r  <= prod[bfe_pkg::RECIP_SH + bfe_pkg::PIX_W - 1:bfe_pkg::RECIP_SH];
      out_row_r       <= s1_row_r;
      out_col_r       <= s1_col_r;
      out_run_end_r   <= s1_run_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_smoothed  = out_smoothed_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_run_end   = out_run_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bfe_pkg::*;

  localparam int RANDOM_ITEMS   = 335;
  localparam int SETTLE_CYCLES  = 10;
  localparam int END_CYCLES     = 20;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = CFG_IDX_W'(15);

  typedef struct packed {
    pix_t   smoothed;
    coord_t row;
    coord_t col;
    logic   run_end;
    logic   frame_end;
  } filt_res_t;

  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_PIXEL_1X1,
    STEP_WRITE
  } step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [DIM_W-1:0]      val;
    pix_t                  want;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_pixel_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_smoothed;
  logic [11:0]          out_row;
  logic [11:0]          out_col;
  logic                 out_run_end;
  logic                 out_frame_end;

  // Shadow of the filter state.
  logic [DIM_W-1:0] width_reg = DIM_W'(640);
  logic [DIM_W-1:0] height_reg = DIM_W'(480);
  pix_t             line_mem [0:2*LB_DEPTH-1];
  pix_t             win [0:2][0:2];
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;

  filt_res_t expected_q [$];
  step_row_t directed_q [$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int n_err = 0;
  int n_pix_in = 0;
  int n_res_out = 0;
  int n_writes = 0;
  int n_in_held = 0;
  int quiet = 0;

  box_filter_3x3_edge_aware u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_smoothed (out_smoothed),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_end  (out_run_end),
    .out_frame_end(out_frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic pix_t nbhd_mean(int cr, int cc, bit up, bit down, bit left, bit right);
    int unsigned sum;
    int unsigned cnt;
    int          i;
    int          j;
    sum = 0;
    cnt = 0;
    for (i = cr - int'(up); i <= cr + int'(down); i++) begin
      for (j = cc - int'(left); j <= cc + int'(right); j++) begin
        sum += win[i][j];
        cnt++;
      end
    end
    return pix_t'(sum / cnt);
  endfunction

  function automatic void predict_pixel(pix_t p, bit typed, pix_t want);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned ci;
    bit          last_c;
    bit          last_r;
    filt_res_t   found [0:3];
    int          n;
    int          i;
    w = clamp_dim(width_reg, LB_DEPTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    if (r >= h) r = h - 1;
    if (c >= w) c = w - 1;
    ci = c % LB_DEPTH;
    last_c = (c == w - 1);
    last_r = (r == h - 1);
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_mem[ci];
    win[1][2] = line_mem[LB_DEPTH + ci];
    win[2][2] = p;
    line_mem[ci] = line_mem[LB_DEPTH + ci];
    line_mem[LB_DEPTH + ci] = p;

    n = 0;
    if (r >= 1 && c >= 1) begin
      found[n] = {nbhd_mean(1, 1, r >= 2, 1'b1, c >= 2, 1'b1),
                  coord_t'(r - 1), coord_t'(c - 1), 1'b0, 1'b0};
      n++;
    end
    if (r >= 1 && last_c) begin
      found[n] = {nbhd_mean(1, 2, r >= 2, 1'b1, c >= 1, 1'b0),
                  coord_t'(r - 1), coord_t'(c), 1'b0, 1'b0};
      n++;
    end
    if (last_r && c >= 1) begin
      found[n] = {nbhd_mean(2, 1, r >= 1, 1'b0, c >= 2, 1'b1),
                  coord_t'(r), coord_t'(c - 1), 1'b0, 1'b0};
      n++;
    end
    if (last_r && last_c) begin
      found[n] = {nbhd_mean(2, 2, r >= 1, 1'b0, c >= 1, 1'b0),
                  coord_t'(r), coord_t'(c), 1'b0, 1'b1};
      n++;
    end
    if (n > 0) found[n-1].run_end = 1'b1;

    if (typed) begin
      expected_q.push_back({want, coord_t'(0), coord_t'(0), 1'b1, 1'b1});
    end else begin
      for (i = 0; i < n; i++) expected_q.push_back(found[i]);
    end

    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void add_step(step_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                   logic [DIM_W-1:0] val, pix_t want);
    directed_q.push_back({kind, idx, val, want});
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      n_err++;
    end
  endtask

  task automatic send_pixel(pix_t p, bit typed, pix_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_pixel(p, typed, want);
    n_pix_in++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = val;
        row_pos = 0;
        col_pos = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = val;
        row_pos = 0;
        col_pos = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : result_check
    filt_res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      n_res_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got row %0d col %0d value %0d",
                 $time, out_row, out_col, out_smoothed);
        n_err++;
      end else begin
        want = expected_q.pop_front();
        check_field("smoothed", want.smoothed, out_smoothed);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("run_end", want.run_end, out_run_end);
        check_field("frame_end", want.frame_end, out_frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid === 1'b1 && in_stall === 1'b1) n_in_held++;
    if (!rst_n || cfg_we || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet, expected_q.size());
      $display("box_filter_3x3_edge_aware: mismatch");
      $finish;
    end
  end

  initial begin
    step_row_t   s;
    int          ph;
    int          k;
    int          w;
    int          h;
    int          area;
    int          count;
    int          rand_items;
    pix_t        p;

    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;

    // Three pixels at reset size, then 1x1, 3x3, 4096x1 and 1x4096 frames.
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(17), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_HEIGHT, DIM_W'(0), 8'd0);
    add_step(STEP_PIXEL_1X1, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_PIXEL_1X1, REG_IMAGE_WIDTH, DIM_W'(255), 8'd255);
    add_step(STEP_PIXEL_1X1, REG_IMAGE_WIDTH, DIM_W'(8'h5a), 8'h5a);
    add_step(STEP_WRITE, REG_IMAGE_WIDTH, DIM_W'(1), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_HEIGHT, DIM_W'(1), 8'd0);
    add_step(STEP_PIXEL_1X1, REG_IMAGE_WIDTH, DIM_W'(8'ha5), 8'ha5);
    add_step(STEP_WRITE, REG_LAST_SPARE, DIM_W'(8191), 8'd0);
    add_step(STEP_PIXEL_1X1, REG_IMAGE_WIDTH, DIM_W'(8'h3c), 8'h3c);
    add_step(STEP_WRITE, REG_IMAGE_WIDTH, DIM_W'(3), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_HEIGHT, DIM_W'(3), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(200), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(13), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(77), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(128), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_WIDTH, DIM_W'(8191), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_HEIGHT, DIM_W'(1), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(254), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(1), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_WIDTH, DIM_W'(1), 8'd0);
    add_step(STEP_WRITE, REG_IMAGE_HEIGHT, DIM_W'(8191), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(255), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(3), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(0), 8'd0);
    add_step(STEP_PIXEL, REG_IMAGE_WIDTH, DIM_W'(250), 8'd0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) begin
      s = directed_q[i];
      case (s.kind)
        STEP_WRITE:     write_reg(s.idx, s.val);
        STEP_PIXEL:     send_pixel(pix_t'(s.val), 1'b0, '0);
        STEP_PIXEL_1X1: send_pixel(pix_t'(s.val), 1'b1, s.want);
        default: ;
      endcase
    end

    rand_items = 0;
    for (ph = 0; rand_items < RANDOM_ITEMS; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 46; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 46; end
        default: begin in_idle_pct = 11; out_stall_pct = 11; end
      endcase
      if (ph % 6 == 4) begin
        w = 7;
        h = 5;
        count = 35;
      end else begin
        case ($urandom_range(9))
          0: begin
            w = $urandom_range(4097, 8191);
            h = 1;
            count = $urandom_range(3, 12);
          end
          1: begin
            w = 1;
            h = $urandom_range(9, 8191);
            count = $urandom_range(3, 12);
          end
          2: begin
            w = $urandom_range(10, 40);
            h = 2;
            count = 2 * w;
          end
          default: begin
            w = $urandom_range(0, 9);
            h = $urandom_range(0, 7);
            area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            count = area * $urandom_range(1, 2);
            if ($urandom_range(2) == 0) count += $urandom_range(0, area - 1);
            if (count > 80) count = 80;
          end
        endcase
      end

      if ($urandom_range(3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                  DIM_W'($urandom));
      end
      if ($urandom_range(1) == 1) begin
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
      end

      for (k = 0; k < count && rand_items < RANDOM_ITEMS; k++) begin
        if (ph % 6 == 4 && k == 4) hold_req = 1'b1;
        if (ph % 6 == 2 && k == count / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_q.size() != 0) @(posedge clk);
        end
        if ($urandom_range(5) == 0) begin
          p = ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
        end else begin
          p = pix_t'($urandom_range(255));
        end
        send_pixel(p, 1'b0, '0);
        rand_items++;
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("Sent %0d pixels across %0d register writes and checked %0d results;",
             n_pix_in, n_writes, n_res_out);
    $display("the input was held off for %0d cycles with a pixel waiting.", n_in_held);
    if (n_err == 0) begin
      $display("box_filter_3x3_edge_aware: match");
    end else begin
      $display("box_filter_3x3_edge_aware: mismatch");
    end
    $finish;
  end

endmodule
